/* rtl/adc_scan_window_alarm_core_defines.svh */
// Assertion macros used by the checker file of the scanner core.
`ifndef ADC_SCAN_WINDOW_ALARM_CORE_DEFINES_SVH
`define ADC_SCAN_WINDOW_ALARM_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/asw_pkg.sv */
`default_nettype none
package asw_pkg;

  // Number of scanned channels and derived widths
  localparam int NUM_CHANNELS = 8;
  localparam int IDX_W = 4;
  localparam int CH_W = 3;
  localparam int SEL_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Bit fill shift: full scale reads all ones
  localparam int FILL_SHIFT = 10;

  // Threshold sentinels that disable a window check
  localparam logic [15:0] LOW_OFF = 16'hFFFF;
  localparam logic [15:0] HIGH_OFF = 16'h0000;

  // Select register fields
  localparam logic [1:0] REF_INTERNAL = 2'b11;
  localparam logic [1:0] REF_SUPPLY = 2'b01;
  localparam logic LEFT_ADJ = 1'b1;

  // Internal source codes and what they map to on the multiplexer
  localparam logic [3:0] ALT_BANDGAP = 4'd0;
  localparam logic [3:0] ALT_GROUND = 4'd1;
  localparam logic [3:0] ALT_TEMP = 4'd2;
  localparam logic [3:0] SRC_BANDGAP = 4'hE;
  localparam logic [3:0] SRC_GROUND = 4'hF;
  localparam logic [3:0] SRC_TEMP = 4'h8;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_SETUP = 2'd1,
    FUNC_LIMIT = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STEP_SELECT = 2'd0,
    STEP_WAIT = 2'd1,
    STEP_START = 2'd2,
    STEP_DONE = 2'd3
  } step_t;

  typedef struct packed {
    func_t func;
    logic [CH_W-1:0] channel;
    logic conv_done;
    logic [15:0] sample;
    logic use_internal_ref;
    logic alt_source;
    logic [3:0] mux_sel;
    logic alert_enable;
    logic [15:0] lower_limit;
    logic [15:0] upper_limit;
  } item_t;

  typedef struct packed {
    logic mux_write;
    logic [7:0] mux_value;
    logic start_conv;
    logic sample_valid;
    logic [CH_W-1:0] done_channel;
    logic [15:0] reading;
    logic alarm_low;
    logic alarm_high;
    logic [IDX_W-1:0] changed_mark;
  } res_t;

  typedef struct packed {
    logic alert_enable;
    logic use_internal_ref;
    logic alt_source;
    logic [3:0] mux_sel;
  } chan_setup_t;

  typedef struct packed {
    chan_setup_t setup;
    logic alarm_low;
    logic alarm_high;
    logic [15:0] lower;
    logic [15:0] upper;
  } chan_view_t;

  typedef struct packed {
    logic set;
    logic [SEL_W-1:0] idx;
    logic alarm_low;
    logic alarm_high;
  } alarm_upd_t;

endpackage
`default_nettype wire

/* rtl/asw_chan_regs.sv */
`default_nettype none
module asw_chan_regs import asw_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire item_t            item,
  input  wire alarm_upd_t       alarm_upd,
  input  wire logic [SEL_W-1:0] rd_idx,
  output chan_view_t            chan
);

  chan_setup_t       setup [NUM_CHANNELS];
  logic              alm_lo [NUM_CHANNELS];
  logic              alm_hi [NUM_CHANNELS];
  logic [15:0]       lower [NUM_CHANNELS];
  logic [15:0]       upper [NUM_CHANNELS];
  logic              in_range;
  logic [SEL_W-1:0]  wr_idx;

  // Decode the addressed channel of a setup, limit or clear item
  assign in_range = {1'b0, item.channel} < IDX_W'(NUM_CHANNELS);
  assign wr_idx = SEL_W'(item.channel);

  // Read the channel under scan
  always_comb begin
    chan.setup = setup[rd_idx];
    chan.alarm_low = alm_lo[rd_idx];
    chan.alarm_high = alm_hi[rd_idx];
    chan.lower = lower[rd_idx];
    chan.upper = upper[rd_idx];
  end

  // Update setup, limits and sticky alarms
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        setup[i] <= '0;
        alm_lo[i] <= 1'b0;
        alm_hi[i] <= 1'b0;
        lower[i] <= LOW_OFF;
        upper[i] <= HIGH_OFF;
      end
    end else if (fire) begin
      if (alarm_upd.set) begin
        alm_lo[alarm_upd.idx] <= alarm_upd.alarm_low;
        alm_hi[alarm_upd.idx] <= alarm_upd.alarm_high;
      end
      if (in_range) begin
        case (item.func)
          FUNC_SETUP: begin
            setup[wr_idx].alert_enable <= item.alert_enable;
            setup[wr_idx].use_internal_ref <= item.use_internal_ref;
            setup[wr_idx].alt_source <= item.alt_source;
            setup[wr_idx].mux_sel <= item.mux_sel;
          end
          FUNC_LIMIT: begin
            lower[wr_idx] <= item.lower_limit;
            upper[wr_idx] <= item.upper_limit;
          end
          FUNC_CLEAR: begin
            alm_lo[wr_idx] <= 1'b0;
            alm_hi[wr_idx] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/asw_scan_ctrl.sv */
`default_nettype none
module asw_scan_ctrl import asw_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire item_t            item,
  input  wire chan_view_t       chan,
  output logic [SEL_W-1:0]      rd_idx,
  output alarm_upd_t            alarm_upd,
  output res_t                  res
);

  logic [IDX_W-1:0] scan_index;
  logic [IDX_W-1:0] scan_index_next;
  step_t            scan_step;
  step_t            scan_step_next;
  logic [IDX_W-1:0] max_alarmed;
  logic [IDX_W-1:0] max_alarmed_next;
  logic [IDX_W-1:0] published_mark;
  logic [IDX_W-1:0] published_mark_next;

  logic             is_tick;
  logic             wrap;
  logic [IDX_W-1:0] idx_cur;
  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] max_cur;
  logic [IDX_W-1:0] pub_cur;
  logic [3:0]       src;
  logic             src_ok;
  logic             skip;
  logic             conv_fire;
  logic             finish;
  logic [15:0]      filled;
  logic             new_low;
  logic             new_high;
  logic             fin_low;
  logic             fin_high;

  // Resolve the wrap and the channel under scan
  always_comb begin
    is_tick = item.func == FUNC_TICK;
    wrap = scan_index >= IDX_W'(NUM_CHANNELS);
    idx_cur = wrap ? '0 : scan_index;
    idx_inc = idx_cur + IDX_W'(1);
    max_cur = wrap ? '0 : max_alarmed;
    pub_cur = wrap ? max_alarmed : published_mark;
    rd_idx = idx_cur[SEL_W-1:0];
  end

  // Decode the source, the sample and the window checks
  always_comb begin
    src = chan.setup.mux_sel;
    src_ok = 1'b1;
    if (chan.setup.alt_source) begin
      case (chan.setup.mux_sel)
        ALT_BANDGAP: src = SRC_BANDGAP;
        ALT_GROUND:  src = SRC_GROUND;
        ALT_TEMP:    src = SRC_TEMP;
        default:     src_ok = 1'b0;
      endcase
    end
    skip = (scan_step == STEP_SELECT) && !src_ok;
    conv_fire = (scan_step == STEP_DONE) && item.conv_done;
    finish = skip || conv_fire;
    filled = item.sample | (item.sample >> FILL_SHIFT);
    new_low = chan.alarm_low
      || (chan.setup.alert_enable && chan.lower != LOW_OFF && filled <= chan.lower);
    new_high = chan.alarm_high
      || (chan.setup.alert_enable && chan.upper != HIGH_OFF && filled >= chan.upper);
    fin_low = conv_fire ? new_low : chan.alarm_low;
    fin_high = conv_fire ? new_high : chan.alarm_high;
  end

  // Next scan state
  always_comb begin
    scan_index_next = scan_index;
    scan_step_next = scan_step;
    max_alarmed_next = max_alarmed;
    published_mark_next = published_mark;
    if (is_tick) begin
      scan_index_next = idx_cur;
      max_alarmed_next = max_cur;
      published_mark_next = pub_cur;
      case (scan_step)
        STEP_SELECT: scan_step_next = STEP_WAIT;
        STEP_WAIT:   scan_step_next = STEP_START;
        STEP_START:  scan_step_next = STEP_DONE;
        default:     scan_step_next = STEP_DONE;
      endcase
      if (finish) begin
        scan_index_next = idx_inc;
        scan_step_next = STEP_SELECT;
        if (fin_low || fin_high) begin
          max_alarmed_next = idx_inc;
        end
      end
    end
  end

  // Result fields and alarm write-back
  always_comb begin
    res = '0;
    res.changed_mark = is_tick ? pub_cur : published_mark;
    alarm_upd.set = is_tick && conv_fire && chan.setup.alert_enable;
    alarm_upd.idx = idx_cur[SEL_W-1:0];
    alarm_upd.alarm_low = new_low;
    alarm_upd.alarm_high = new_high;
    if (is_tick) begin
      if (scan_step == STEP_SELECT && src_ok) begin
        res.mux_write = 1'b1;
        res.mux_value = {chan.setup.use_internal_ref ? REF_INTERNAL : REF_SUPPLY,
                         LEFT_ADJ, 1'b0, src};
      end
      if (scan_step == STEP_START) begin
        res.start_conv = 1'b1;
      end
      if (conv_fire) begin
        res.sample_valid = 1'b1;
        res.reading = filled;
      end
      if (finish) begin
        res.done_channel = CH_W'(idx_cur);
        res.alarm_low = fin_low;
        res.alarm_high = fin_high;
      end
    end
  end

  // Hold scan state; advance it on each accepted tick item
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index <= '0;
      scan_step <= STEP_SELECT;
      max_alarmed <= '0;
      published_mark <= '0;
    end else if (fire) begin
      scan_index <= scan_index_next;
      scan_step <= scan_step_next;
      max_alarmed <= max_alarmed_next;
      published_mark <= published_mark_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/adc_scan_window_alarm_core.sv */
// Round-robin converter scanner with a sticky window alarm per channel. Each
// tick item moves the scan one step (select, wait, start, wait for done); other
// items write a channel's setup, its limits, or clear its alarms, and every item
// yields exactly one result. Items enter an input register and leave through a
// result register, so the block accepts one item per clock cycle while the
// output side is ready. A taken item waits in the input register and its
// result in the result register; a single pass of decode and compare logic
// lies between the two registers. Channel state is held in flip-flops and is
// valid right after reset.
`default_nettype none
module adc_scan_window_alarm_core import asw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [2:0]  channel,
  input  wire logic        conv_done,
  input  wire logic [15:0] sample,
  input  wire logic        use_internal_ref,
  input  wire logic        alt_source,
  input  wire logic [3:0]  mux_sel,
  input  wire logic        alert_enable,
  input  wire logic [15:0] lower_limit,
  input  wire logic [15:0] upper_limit,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             mux_write,
  output logic [7:0]       mux_value,
  output logic             start_conv,
  output logic             sample_valid,
  output logic [2:0]       done_channel,
  output logic [15:0]      reading,
  output logic             alarm_low,
  output logic             alarm_high,
  output logic [3:0]       changed_mark
);

  item_t            item_q;
  logic             item_vld;
  logic             fire;
  res_t             res;
  res_t             res_q;
  logic [SEL_W-1:0] rd_idx;
  chan_view_t       chan;
  alarm_upd_t       alarm_upd;

  // Move the held item into the result register when that slot frees up
  assign fire = item_vld && (!out_valid || out_ready);
  assign in_ready = !item_vld || fire;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (in_ready) begin
      item_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.func <= func_t'(func);
      item_q.channel <= channel;
      item_q.conv_done <= conv_done;
      item_q.sample <= sample;
      item_q.use_internal_ref <= use_internal_ref;
      item_q.alt_source <= alt_source;
      item_q.mux_sel <= mux_sel;
      item_q.alert_enable <= alert_enable;
      item_q.lower_limit <= lower_limit;
      item_q.upper_limit <= upper_limit;
    end
  end

  asw_scan_ctrl u_scan (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item_q),
    .chan      (chan),
    .rd_idx    (rd_idx),
    .alarm_upd (alarm_upd),
    .res       (res)
  );

  asw_chan_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item_q),
    .alarm_upd (alarm_upd),
    .rd_idx    (rd_idx),
    .chan      (chan)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign mux_write = res_q.mux_write;
  assign mux_value = res_q.mux_value;
  assign start_conv = res_q.start_conv;
  assign sample_valid = res_q.sample_valid;
  assign done_channel = res_q.done_channel;
  assign reading = res_q.reading;
  assign alarm_low = res_q.alarm_low;
  assign alarm_high = res_q.alarm_high;
  assign changed_mark = res_q.changed_mark;

endmodule
`default_nettype wire

/* rtl/asw_core_chk.sv */
`default_nettype none
`include "adc_scan_window_alarm_core_defines.svh"
module asw_core_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        mux_write,
  input wire logic [7:0]  mux_value,
  input wire logic        start_conv,
  input wire logic        sample_valid,
  input wire logic [15:0] reading,
  input wire logic [2:0]  done_channel,
  input wire logic        alarm_low,
  input wire logic        alarm_high,
  input wire logic [3:0]  changed_mark
);

  // A stalled result keeps its payload
  `ASW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(reading) && $stable(mux_value) && $stable(done_channel) && $stable(changed_mark) && $stable(alarm_low) && $stable(alarm_high), "result changed while stalled")

  // One scan step per tick: select, start and finish never coincide
  `ASW_ASSERT_NOW(a_step_excl, out_valid, !(sample_valid && (mux_write || start_conv)) && !(mux_write && start_conv), "two scan steps in one result")

  // A select write always carries left adjust and a known reference
  `ASW_ASSERT_NOW(a_mux_form, out_valid && mux_write, mux_value[5] && mux_value[6] && !mux_value[4], "malformed select value")

  // No reading without a finished conversion
  `ASW_ASSERT_NOW(a_reading_zero, out_valid && !sample_valid, reading == 16'h0000, "reading without conversion")

endmodule

bind adc_scan_window_alarm_core asw_core_chk u_chk (.*);
`default_nettype wire
